>>> hw/rtl/ospt_pkg.sv
`default_nettype none

package ospt_pkg;

    // Default elapsed/duration time width in bits
    localparam int TIME_WIDTH_DEF = 32;

    // Field widths of the stream and configuration ports
    localparam int OPCODE_W   = 3;
    localparam int TICKS_W    = 32;
    localparam int PROG_W     = 17;
    localparam int FRAC_BITS  = 16;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 104;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // 1.0 in Q1.16
    localparam logic [PROG_W-1:0] Q_ONE = 17'h10000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE = 1'b1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK   = 3'd0,
        OP_START  = 3'd1,
        OP_STOP   = 3'd2,
        OP_RESET  = 3'd3,
        OP_PAUSE  = 3'd4,
        OP_RESUME = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        RUN_STOPPED  = 2'd0,
        RUN_RUNNING  = 2'd1,
        RUN_PAUSED   = 2'd2,
        RUN_FINISHED = 2'd3
    } run_state_t;

    // Sequencer states
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MOD,
        SEQ_CHECK,
        SEQ_FRAC,
        SEQ_EMIT
    } seq_state_t;

    // Divider control: start pulse and operation select
    typedef struct packed {
        logic start;
        logic frac_mode;
    } div_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/ospt_divider.sv
`default_nettype none

// Shared restoring divider, one quotient bit per cycle.
// Modulo mode: rem = num % den after W steps.
// Fraction mode (num < den): quot = floor(num * 2^16 / den) after 16 steps.
module ospt_divider #(
    parameter int W = ospt_pkg::TIME_WIDTH_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire ospt_pkg::div_ctrl_t             ctrl,
    input  wire logic [W-1:0]                    num,
    input  wire logic [W-1:0]                    den,
    output logic                                 done,
    output logic [W-1:0]                         rem,
    output logic [ospt_pkg::FRAC_BITS-1:0]       quot
);

    localparam int ITER_MAX = (W > ospt_pkg::FRAC_BITS) ? W : ospt_pkg::FRAC_BITS;
    localparam int CNT_W    = $clog2(ITER_MAX + 1);

    logic                              busy_reg;
    logic                              done_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [W-1:0]                      rem_reg;
    logic [W-1:0]                      shf_reg;
    logic [ospt_pkg::FRAC_BITS-1:0]    quot_reg;

    logic [W:0]                        trial;
    logic [W:0]                        diff;
    logic                              ge;
    logic [W-1:0]                      rem_step;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, shf_reg[W-1]};
        diff     = trial - {1'b0, den};
        ge       = (trial >= {1'b0, den});
        rem_step = ge ? diff[W-1:0] : trial[W-1:0];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ctrl.frac_mode ? CNT_W'(ospt_pkg::FRAC_BITS) : CNT_W'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg  <= ctrl.frac_mode ? num : '0;
            shf_reg  <= ctrl.frac_mode ? '0 : num;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_step;
            shf_reg  <= {shf_reg[W-2:0], 1'b0};
            quot_reg <= {quot_reg[ospt_pkg::FRAC_BITS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

>>> hw/rtl/one_shot_periodic_timer_core.sv
`default_nettype none

// One-shot / periodic timer. Each command on the input stream (tick, start,
// stop, reset, pause, resume) yields exactly one status transaction on the
// output stream: run state, elapsed and remaining ticks, Q1.16 progress and
// its complement, and the finished/looped flags. All division goes through
// one shared restoring divider that retires one bit per cycle. A command
// occupies the core from acceptance until the next command can be accepted.
// Progress is set to 1.0 directly when it is trivial (duration zero or
// elapsed at or past the duration); otherwise the Q0.16 fraction is
// computed, and when a looping tick wraps the modulo runs first. A previous
// status still waiting in the output register holds the command until the
// register is free. Input is not accepted while a command is in progress; a
// finished status waits in the output register without holding up the next
// command. Configuration writes are taken every cycle.
module one_shot_periodic_timer_core #(
    parameter int TIME_WIDTH = ospt_pkg::TIME_WIDTH_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // opcode[2:0], delta[34:3], zero pad [39:35]
    input  wire logic [ospt_pkg::S_DATA_W-1:0]    s_tdata,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // run_state[1:0], elapsed[33:2], remaining[65:34], progress[82:66],
    // reverse_progress[99:83], finished_flag[100], looped_flag[101], pad [103:102]
    output logic [ospt_pkg::M_DATA_W-1:0]         m_tdata,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    input  wire logic [ospt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ospt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready
);

    localparam int TW = TIME_WIDTH;

    // Configuration
    logic [ospt_pkg::TICKS_W-1:0] duration_reg;
    logic                         loop_mode_reg;

    // Timer state
    ospt_pkg::run_state_t         run_state_reg, run_state_next;
    logic [TW-1:0]                elapsed_reg, elapsed_next;
    logic                         finished_reg, finished_next;
    logic                         looped_reg, looped_next;
    logic [ospt_pkg::PROG_W-1:0]  prog_reg, prog_next;

    // Sequencer
    ospt_pkg::seq_state_t         seq_reg, seq_next;

    // Output register
    logic                         m_tvalid_reg;
    logic [ospt_pkg::M_DATA_W-1:0] m_tdata_reg;

    // Divider interface
    ospt_pkg::div_ctrl_t          div_ctrl;
    logic [TW-1:0]                div_num;
    logic                         div_done;
    logic [TW-1:0]                div_rem;
    logic [ospt_pkg::FRAC_BITS-1:0] div_quot;

    logic                         s_accept;
    logic                         out_free;
    ospt_pkg::opcode_t            opcode;
    logic [TW-1:0]                delta_tw;
    logic [TW-1:0]                dur_tw;
    logic [TW:0]                  sum_raw;
    logic [TW-1:0]                sum_sat;
    logic                         tick_run;
    logic                         tick_hit;
    logic                         tick_wrap;
    logic                         need_frac;
    logic [TW-1:0]                remaining_tw;
    logic [ospt_pkg::PROG_W-1:0]  rev_prog;

    assign s_tready  = (seq_reg == ospt_pkg::SEQ_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Field unpacking and tick arithmetic
    always_comb
    begin
        opcode    = ospt_pkg::opcode_t'(s_tdata[ospt_pkg::OPCODE_W-1:0]);
        delta_tw  = TW'(s_tdata[ospt_pkg::OPCODE_W +: ospt_pkg::TICKS_W]);
        dur_tw    = TW'(duration_reg);
        sum_raw   = {1'b0, elapsed_reg} + {1'b0, delta_tw};
        sum_sat   = sum_raw[TW] ? {TW{1'b1}} : sum_raw[TW-1:0];
        tick_run  = (opcode == ospt_pkg::OP_TICK) && (run_state_reg == ospt_pkg::RUN_RUNNING);
        tick_hit  = tick_run && (sum_sat >= dur_tw);
        tick_wrap = tick_hit && loop_mode_reg && (dur_tw != '0);
        need_frac = (dur_tw != '0) && (elapsed_reg < dur_tw);
    end

    // Sequencer next state
    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            ospt_pkg::SEQ_IDLE:
            begin
                if (s_accept)
                    seq_next = tick_wrap ? ospt_pkg::SEQ_MOD : ospt_pkg::SEQ_CHECK;
            end
            ospt_pkg::SEQ_MOD:
            begin
                if (div_done)
                    seq_next = ospt_pkg::SEQ_CHECK;
            end
            ospt_pkg::SEQ_CHECK:
            begin
                seq_next = need_frac ? ospt_pkg::SEQ_FRAC : ospt_pkg::SEQ_EMIT;
            end
            ospt_pkg::SEQ_FRAC:
            begin
                if (div_done)
                    seq_next = ospt_pkg::SEQ_EMIT;
            end
            ospt_pkg::SEQ_EMIT:
            begin
                if (out_free)
                    seq_next = ospt_pkg::SEQ_IDLE;
            end
            default:
            begin
                seq_next = ospt_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs: command effects, divider control, progress
    always_comb
    begin
        run_state_next     = run_state_reg;
        elapsed_next       = elapsed_reg;
        finished_next      = finished_reg;
        looped_next        = looped_reg;
        prog_next          = prog_reg;
        div_ctrl.start     = 1'b0;
        div_ctrl.frac_mode = 1'b0;
        div_num            = elapsed_reg;

        unique case (seq_reg)
            ospt_pkg::SEQ_IDLE:
            begin
                if (s_accept)
                begin
                    priority case (opcode)
                        ospt_pkg::OP_TICK:
                        begin
                            if (tick_run)
                            begin
                                finished_next = tick_hit;
                                looped_next   = tick_wrap;
                                elapsed_next  = sum_sat;
                                if (tick_wrap)
                                begin
                                    div_ctrl.start = 1'b1;
                                    div_num        = sum_sat;
                                end
                                else if (tick_hit)
                                begin
                                    elapsed_next   = dur_tw;
                                    run_state_next = ospt_pkg::RUN_FINISHED;
                                end
                            end
                        end
                        ospt_pkg::OP_START:
                        begin
                            elapsed_next   = '0;
                            finished_next  = 1'b0;
                            looped_next    = 1'b0;
                            run_state_next = ospt_pkg::RUN_RUNNING;
                        end
                        ospt_pkg::OP_STOP:
                        begin
                            finished_next  = 1'b0;
                            looped_next    = 1'b0;
                            run_state_next = ospt_pkg::RUN_STOPPED;
                        end
                        ospt_pkg::OP_RESET:
                        begin
                            elapsed_next   = '0;
                            finished_next  = 1'b0;
                            looped_next    = 1'b0;
                            run_state_next = ospt_pkg::RUN_STOPPED;
                        end
                        ospt_pkg::OP_PAUSE:
                        begin
                            if (run_state_reg == ospt_pkg::RUN_RUNNING)
                                run_state_next = ospt_pkg::RUN_PAUSED;
                        end
                        ospt_pkg::OP_RESUME:
                        begin
                            if ((run_state_reg == ospt_pkg::RUN_PAUSED) &&
                                (elapsed_reg < dur_tw))
                            begin
                                run_state_next = ospt_pkg::RUN_RUNNING;
                                finished_next  = 1'b0;
                                looped_next    = 1'b0;
                            end
                        end
                        default:
                        begin
                            // unused opcodes: report status only
                        end
                    endcase
                end
            end
            ospt_pkg::SEQ_MOD:
            begin
                if (div_done)
                    elapsed_next = div_rem;
            end
            ospt_pkg::SEQ_CHECK:
            begin
                if (need_frac)
                begin
                    div_ctrl.start     = 1'b1;
                    div_ctrl.frac_mode = 1'b1;
                end
                else
                begin
                    prog_next = ospt_pkg::Q_ONE;
                end
            end
            ospt_pkg::SEQ_FRAC:
            begin
                if (div_done)
                    prog_next = {1'b0, div_quot};
            end
            ospt_pkg::SEQ_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Status fields for the output transaction
    always_comb
    begin
        remaining_tw = (elapsed_reg < dur_tw) ? (dur_tw - elapsed_reg) : '0;
        rev_prog     = ospt_pkg::Q_ONE - prog_reg;
    end

    // State and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= ospt_pkg::SEQ_IDLE;
            run_state_reg <= ospt_pkg::RUN_STOPPED;
            elapsed_reg   <= '0;
            finished_reg  <= 1'b0;
            looped_reg    <= 1'b0;
            duration_reg  <= '0;
            loop_mode_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            run_state_reg <= run_state_next;
            elapsed_reg   <= elapsed_next;
            finished_reg  <= finished_next;
            looped_reg    <= looped_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ospt_pkg::CFG_DURATION:  duration_reg  <= cfg_data;
                    ospt_pkg::CFG_LOOP_MODE: loop_mode_reg <= cfg_data[0];
                    default:                 ;
                endcase
            end

            if ((seq_reg == ospt_pkg::SEQ_EMIT) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prog_reg <= prog_next;
        if ((seq_reg == ospt_pkg::SEQ_EMIT) && out_free)
        begin
            m_tdata_reg <= {2'b00,
                            looped_reg,
                            finished_reg,
                            rev_prog,
                            prog_reg,
                            ospt_pkg::TICKS_W'(remaining_tw),
                            ospt_pkg::TICKS_W'(elapsed_reg),
                            run_state_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Shared divider for modulo wrap and progress fraction
    ospt_divider #(
        .W (TW)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (div_num),
        .den   (dur_tw),
        .done  (div_done),
        .rem   (div_rem),
        .quot  (div_quot)
    );

endmodule

`default_nettype wire

>>> verif/one_shot_periodic_timer_core_test.sv
module one_shot_periodic_timer_core_test;

    import ospt_pkg::*;

    // Opcodes outside the defined set; the core reports status unchanged
    localparam logic [OPCODE_W-1:0] OP_NOP6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_NOP7 = 3'd7;

    localparam int DRAIN_CYCLES = 60;

    // One status transaction as seen on m_tdata
    typedef struct packed {
        run_state_t        state;
        logic [TICKS_W-1:0] elapsed;
        logic [TICKS_W-1:0] remaining;
        logic [PROG_W-1:0]  progress;
        logic [PROG_W-1:0]  rev_progress;
        logic               finished;
        logic               looped;
    } timer_status_t;

    // One row of the directed stimulus: either a register update or a command
    typedef struct packed {
        logic                is_cfg;
        logic                set_dur;
        logic [TICKS_W-1:0]  dur;
        logic                set_loop;
        logic                loop_v;
        logic [OPCODE_W-1:0] op;
        logic [TICKS_W-1:0]  delta;
        logic                has_gold;
        timer_status_t       gold;
    } stim_row_t;

    // Status values that are obvious from the spec
    localparam timer_status_t ST_IDLE0 =
        '{RUN_STOPPED, 32'd0, 32'd0, Q_ONE, 17'd0, 1'b0, 1'b0};
    localparam timer_status_t ST_RUN0 =
        '{RUN_RUNNING, 32'd0, 32'd0, Q_ONE, 17'd0, 1'b0, 1'b0};
    localparam timer_status_t ST_PAUSE0 =
        '{RUN_PAUSED, 32'd0, 32'd0, Q_ONE, 17'd0, 1'b0, 1'b0};
    localparam timer_status_t ST_FIN0 =
        '{RUN_FINISHED, 32'd0, 32'd0, Q_ONE, 17'd0, 1'b1, 1'b0};
    localparam timer_status_t ST_FULLRUN =
        '{RUN_RUNNING, 32'd0, 32'hFFFF_FFFF, 17'd0, Q_ONE, 1'b0, 1'b0};
    localparam timer_status_t ST_RESET500 =
        '{RUN_STOPPED, 32'd0, 32'd500, 17'd0, Q_ONE, 1'b0, 1'b0};

    logic                  clk;
    logic                  rst_n;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  cfg_valid;
    logic                  cfg_ready;

    // Timer model state and its configuration
    run_state_t         tmr_state    = RUN_STOPPED;
    logic [TICKS_W-1:0] tmr_elapsed  = '0;
    logic               tmr_finished = 1'b0;
    logic               tmr_looped   = 1'b0;
    logic [TICKS_W-1:0] cfg_duration_r = '0;
    logic               cfg_loop_r     = 1'b0;

    timer_status_t pending_status[$];
    stim_row_t     dir_rows[$];

    int send_idle = 35;
    int recv_idle = 51;
    int fail_count = 0;

    one_shot_periodic_timer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("one_shot_periodic_timer_core_test NOT OK");
        $finish;
    end

    // Apply one command to the timer model and return the status it reports
    function automatic timer_status_t advance_timer(input logic [OPCODE_W-1:0] op,
                                                    input logic [TICKS_W-1:0] delta,
                                                    output bit acted);
        logic [TICKS_W:0]   sum;
        logic [47:0]        scaled;
        timer_status_t      s;
        acted = 1'b1;
        case (op)
            OP_TICK:
            begin
                if (tmr_state == RUN_RUNNING)
                begin
                    tmr_finished = 1'b0;
                    tmr_looped   = 1'b0;
                    sum = {1'b0, tmr_elapsed} + {1'b0, delta};
                    // saturate on overflow
                    tmr_elapsed = sum[TICKS_W] ? '1 : sum[TICKS_W-1:0];
                    if (tmr_elapsed >= cfg_duration_r)
                    begin
                        tmr_finished = 1'b1;
                        if (cfg_loop_r && cfg_duration_r != 0)
                        begin
                            tmr_elapsed = tmr_elapsed % cfg_duration_r;
                            tmr_looped  = 1'b1;
                        end
                        else
                        begin
                            tmr_elapsed = cfg_duration_r;
                            tmr_state   = RUN_FINISHED;
                        end
                    end
                end
                else
                    acted = 1'b0;
            end
            OP_START, OP_RESET:
            begin
                tmr_elapsed  = '0;
                tmr_finished = 1'b0;
                tmr_looped   = 1'b0;
                tmr_state    = (op == OP_START) ? RUN_RUNNING : RUN_STOPPED;
            end
            OP_STOP:
            begin
                tmr_state    = RUN_STOPPED;
                tmr_finished = 1'b0;
                tmr_looped   = 1'b0;
            end
            OP_PAUSE:
            begin
                if (tmr_state == RUN_RUNNING)
                    tmr_state = RUN_PAUSED;
                else
                    acted = 1'b0;
            end
            OP_RESUME:
            begin
                if (tmr_state == RUN_PAUSED && tmr_elapsed < cfg_duration_r)
                begin
                    tmr_state    = RUN_RUNNING;
                    tmr_finished = 1'b0;
                    tmr_looped   = 1'b0;
                end
                else
                    acted = 1'b0;
            end
            default:
                acted = 1'b0;
        endcase

        s.state     = tmr_state;
        s.elapsed   = tmr_elapsed;
        s.remaining = (tmr_elapsed < cfg_duration_r) ? cfg_duration_r - tmr_elapsed : '0;
        if (cfg_duration_r == 0 || tmr_elapsed >= cfg_duration_r)
            s.progress = Q_ONE;
        else
        begin
            scaled     = {tmr_elapsed, 16'h0000};
            s.progress = PROG_W'(scaled / cfg_duration_r);
        end
        s.rev_progress = Q_ONE - s.progress;
        s.finished     = tmr_finished;
        s.looped       = tmr_looped;
        return s;
    endfunction

    function automatic stim_row_t cmd_row(input logic [OPCODE_W-1:0] op,
                                          input logic [TICKS_W-1:0] delta);
        stim_row_t r;
        r       = '0;
        r.op    = op;
        r.delta = delta;
        return r;
    endfunction

    function automatic stim_row_t gold_row(input logic [OPCODE_W-1:0] op,
                                           input logic [TICKS_W-1:0] delta,
                                           input timer_status_t gold);
        stim_row_t r;
        r          = cmd_row(op, delta);
        r.has_gold = 1'b1;
        r.gold     = gold;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic set_dur, input logic [TICKS_W-1:0] dur,
                                          input logic set_loop, input logic loop_v);
        stim_row_t r;
        r          = '0;
        r.is_cfg   = 1'b1;
        r.set_dur  = set_dur;
        r.dur      = dur;
        r.set_loop = set_loop;
        r.loop_v   = loop_v;
        return r;
    endfunction

    // Random period: mostly short, with the extremes mixed in
    function automatic logic [TICKS_W-1:0] pick_duration();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'd1;
            3: return $urandom_range(2, 16);
            4: return $urandom_range(17, 4096);
            5: return $urandom_range(4097, 32'h0100_0000);
            6: return $urandom;
            7: return 32'h8000_0000 | $urandom_range(0, 3);
            default: return $urandom_range(100, 100000);
        endcase
    endfunction

    // Tick size scaled to the period, plus exact hits and the extremes
    function automatic logic [TICKS_W-1:0] tick_delta();
        logic [TICKS_W-1:0] span;
        span = (cfg_duration_r == 0) ? 32'd16 : cfg_duration_r;
        case ($urandom_range(11))
            0: return '0;
            1: return '1;
            2: return $urandom;
            3: return (tmr_elapsed < cfg_duration_r) ? cfg_duration_r - tmr_elapsed : '0;
            4: return span + $urandom_range(0, span >> 1);
            default: return $urandom_range(0, span / 3);
        endcase
    endfunction

    // Stop sending and wait for every outstanding status
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Register update, only with the core idle
    task automatic config_timer(input logic set_dur, input logic [TICKS_W-1:0] dur,
                                input logic set_loop, input logic loop_v);
        logic [CFG_DATA_W-1:0] loop_word;
        loop_word    = $urandom;
        loop_word[0] = loop_v;
        wait_idle();
        if (set_dur)
        begin
            put_reg(CFG_DURATION, dur);
            cfg_duration_r = dur;
        end
        if (set_loop)
        begin
            put_reg(CFG_LOOP_MODE, loop_word);
            cfg_loop_r = loop_v;
        end
        if (set_dur || set_loop)
            cfg_valid <= 1'b0;
    endtask

    // Send one command transaction and queue the status it should produce
    task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [TICKS_W-1:0] delta,
                            input logic use_gold, input timer_status_t gold,
                            output bit acted);
        timer_status_t predicted;
        while (send_idle != 0 && $urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {{(S_DATA_W-OPCODE_W-TICKS_W){1'b0}}, delta, op};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        predicted = advance_timer(op, delta, acted);
        pending_status.push_back(use_gold ? gold : predicted);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Output backpressure
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Status checker: compare each accepted transaction with the oldest prediction
    always @(posedge clk)
    begin : status_check
        timer_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_status.size() == 0)
            begin
                $error("status transaction with nothing pending: %0h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("run_state", want.state, m_tdata[1:0]);
                check_field("elapsed", want.elapsed, m_tdata[33:2]);
                check_field("remaining", want.remaining, m_tdata[65:34]);
                check_field("progress", want.progress, m_tdata[82:66]);
                check_field("reverse_progress", want.rev_progress, m_tdata[99:83]);
                check_field("finished_flag", want.finished, m_tdata[100]);
                check_field("looped_flag", want.looped, m_tdata[101]);
            end
        end
    end

    initial
    begin : main
        bit                  acted;
        int                  active_cnt;
        int                  chunk_left;
        int                  r;
        logic [OPCODE_W-1:0] op;
        logic [TICKS_W-1:0]  delta;

        rst_n     <= 1'b0;
        s_tdata   <= '0;
        s_tvalid  <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        cfg_valid <= 1'b0;

        // Directed: zero period, ignored commands, flag hold, full-scale and
        // saturating ticks, resume blocked by a shortened period, exact wrap
        dir_rows.push_back(cfg_row(1'b1, 32'd0, 1'b1, 1'b0));
        dir_rows.push_back(gold_row(OP_STOP, 32'd0, ST_IDLE0));
        dir_rows.push_back(gold_row(OP_TICK, 32'hFFFF_FFFF, ST_IDLE0));
        dir_rows.push_back(gold_row(OP_START, 32'd0, ST_RUN0));
        dir_rows.push_back(gold_row(OP_PAUSE, 32'd0, ST_PAUSE0));
        dir_rows.push_back(gold_row(OP_RESUME, 32'd0, ST_PAUSE0));
        dir_rows.push_back(gold_row(OP_START, 32'd0, ST_RUN0));
        dir_rows.push_back(gold_row(OP_TICK, 32'd0, ST_FIN0));
        dir_rows.push_back(gold_row(OP_RESUME, 32'd0, ST_FIN0));
        dir_rows.push_back(gold_row(OP_NOP6, 32'hFFFF_FFFF, ST_FIN0));
        dir_rows.push_back(gold_row(OP_NOP7, 32'h5555_AAAA, ST_FIN0));
        dir_rows.push_back(gold_row(OP_PAUSE, 32'd0, ST_FIN0));
        dir_rows.push_back(cfg_row(1'b0, 32'd0, 1'b1, 1'b1));
        dir_rows.push_back(gold_row(OP_START, 32'd0, ST_RUN0));
        dir_rows.push_back(gold_row(OP_TICK, 32'd7, ST_FIN0));
        dir_rows.push_back(cfg_row(1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0));
        dir_rows.push_back(gold_row(OP_START, 32'd0, ST_FULLRUN));
        dir_rows.push_back(cmd_row(OP_TICK, 32'hFFFF_FFFE));
        dir_rows.push_back(cmd_row(OP_PAUSE, 32'd0));
        dir_rows.push_back(cmd_row(OP_RESUME, 32'd0));
        dir_rows.push_back(cmd_row(OP_TICK, 32'hFFFF_FFFF));
        dir_rows.push_back(cmd_row(OP_STOP, 32'd0));
        dir_rows.push_back(cfg_row(1'b1, 32'd1000, 1'b1, 1'b0));
        dir_rows.push_back(cmd_row(OP_START, 32'd0));
        dir_rows.push_back(cmd_row(OP_TICK, 32'd999));
        dir_rows.push_back(cmd_row(OP_PAUSE, 32'd0));
        dir_rows.push_back(cfg_row(1'b1, 32'd500, 1'b0, 1'b0));
        dir_rows.push_back(cmd_row(OP_RESUME, 32'd0));
        dir_rows.push_back(cmd_row(OP_TICK, 32'd3));
        dir_rows.push_back(gold_row(OP_RESET, 32'd0, ST_RESET500));
        dir_rows.push_back(cfg_row(1'b1, 32'd3, 1'b1, 1'b1));
        dir_rows.push_back(cmd_row(OP_START, 32'd0));
        dir_rows.push_back(cmd_row(OP_TICK, 32'd10));
        dir_rows.push_back(cmd_row(OP_TICK, 32'd2));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                config_timer(dir_rows[i].set_dur, dir_rows[i].dur,
                             dir_rows[i].set_loop, dir_rows[i].loop_v);
            else
                send_cmd(dir_rows[i].op, dir_rows[i].delta, dir_rows[i].has_gold,
                         dir_rows[i].gold, acted);
        end

        // Random: mostly start/tick runs with pauses, some noise, in three idle phases
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 35;
                    recv_idle = 51;
                end
                1:
                begin
                    send_idle = 51;
                    recv_idle = 35;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            active_cnt = 0;
            chunk_left = 0;
            while (active_cnt < 550)
            begin
                if (chunk_left == 0)
                begin
                    config_timer($urandom_range(3) != 0, pick_duration(),
                                 $urandom_range(3) != 0, $urandom_range(1));
                    chunk_left = $urandom_range(30, 90);
                end
                r = $urandom_range(99);
                if ((tmr_state == RUN_STOPPED || tmr_state == RUN_FINISHED) && r < 55)
                    op = OP_START;
                else if (tmr_state == RUN_PAUSED && r < 40)
                    op = OP_RESUME;
                else if (r < 6)
                    op = OP_START;
                else if (r < 66)
                    op = OP_TICK;
                else if (r < 72)
                    op = OP_PAUSE;
                else if (r < 78)
                    op = OP_RESUME;
                else if (r < 82)
                    op = OP_STOP;
                else if (r < 86)
                    op = OP_RESET;
                else
                    op = $urandom_range(7);
                delta = (op == OP_TICK) ? tick_delta() : $urandom;
                send_cmd(op, delta, 1'b0, ST_IDLE0, acted);
                // every command counts toward the total, acted on or not
                active_cnt++;
                chunk_left--;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("one_shot_periodic_timer_core_test OK");
        else
            $display("one_shot_periodic_timer_core_test NOT OK");
        $finish;
    end

endmodule
